// ===== rtl/lodc_pkg.sv =====
// Shared types, constants and calendar functions for the overdue day counter.
`timescale 1ns / 1ps

package lodc_pkg;

	localparam int DATE_W = 25;
	localparam int ALLOW_W = 16;
	localparam int ELAPSED_W = 15;
	localparam int YEAR_W = 14;
	localparam int ACC_W = 24;
	localparam int QUO_W = 12;
	localparam int REM_W = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W = 7;
	localparam int CENT_W = 7;

	localparam int FIRST_YEAR_DEF = 2019;
	localparam int LAST_YEAR_DEF = 2050;

	localparam int DIV_BIG = 10000;
	localparam int DIV_SMALL = 100;
	localparam int SHIFT_BIG = 39;
	localparam int SHIFT_SMALL = 32;
	localparam int RECIP_W = 26;
	localparam longint RECIP_BIG =
		((longint'(1) << SHIFT_BIG) + longint'(DIV_BIG) - 1) / longint'(DIV_BIG);
	localparam longint RECIP_SMALL =
		((longint'(1) << SHIFT_SMALL) + longint'(DIV_SMALL) - 1) / longint'(DIV_SMALL);
	localparam int DAYS_YEAR = 365;
	localparam int MONTHS = 12;
	localparam int ELAPSED_MAX = (1 << (ELAPSED_W - 1)) - 1;
	localparam int ELAPSED_MIN = -(1 << (ELAPSED_W - 1));

	typedef struct packed {
		logic start;
		logic by_100;
	} div_req_t;

	function automatic logic leap_of(input logic [CENT_W-1:0] cent,
			input logic [DAY_W-1:0] yr_in_cent);
		logic leap;
		if (yr_in_cent != '0) begin
			leap = (yr_in_cent[1:0] == 2'b00);
		end else begin
			leap = (cent[1:0] == 2'b00);
		end
		return leap;
	endfunction

	function automatic logic [8:0] days_before(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [8:0] base;
		case (month)
			4'd1: base = 9'd0;
			4'd2: base = 9'd31;
			4'd3: base = 9'd59;
			4'd4: base = 9'd90;
			4'd5: base = 9'd120;
			4'd6: base = 9'd151;
			4'd7: base = 9'd181;
			4'd8: base = 9'd212;
			4'd9: base = 9'd243;
			4'd10: base = 9'd273;
			4'd11: base = 9'd304;
			4'd12: base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && month > 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ===== rtl/lodc_cdiv.sv =====
// Divider by a constant (10000 or 100) through a reciprocal multiply; done follows start through busy_q and done_q.
`timescale 1ns / 1ps

module lodc_cdiv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lodc_pkg::div_req_t               req,
	input  logic [lodc_pkg::DATE_W-1:0]      num,
	output logic                             done,
	output logic [lodc_pkg::QUO_W-1:0]       quo,
	output logic [lodc_pkg::REM_W-1:0]       rem
);

	localparam int PROD_W = lodc_pkg::DATE_W + lodc_pkg::RECIP_W;
	localparam logic [lodc_pkg::DATE_W-1:0] DIV_BIG_C = lodc_pkg::DATE_W'(lodc_pkg::DIV_BIG);
	localparam logic [lodc_pkg::DATE_W-1:0] DIV_SMALL_C =
		lodc_pkg::DATE_W'(lodc_pkg::DIV_SMALL);
	localparam logic [lodc_pkg::RECIP_W-1:0] RECIP_BIG_C =
		lodc_pkg::RECIP_W'(lodc_pkg::RECIP_BIG);
	localparam logic [lodc_pkg::RECIP_W-1:0] RECIP_SMALL_C =
		lodc_pkg::RECIP_W'(lodc_pkg::RECIP_SMALL);

	logic                             busy_q;
	logic                             done_q;
	logic                             by100_q;
	logic [lodc_pkg::DATE_W-1:0]      num_q;
	logic [lodc_pkg::QUO_W-1:0]       quo_q;
	logic [PROD_W-1:0]                prod;
	logic [lodc_pkg::QUO_W-1:0]       quo_nx;
	logic [lodc_pkg::DATE_W-1:0]      back;
	logic [lodc_pkg::DATE_W-1:0]      rem_x;

	always_comb begin
		prod = PROD_W'(num_q) * PROD_W'(by100_q ? RECIP_SMALL_C : RECIP_BIG_C);
		quo_nx = by100_q ? prod[lodc_pkg::SHIFT_SMALL +: lodc_pkg::QUO_W]
			: prod[lodc_pkg::SHIFT_BIG +: lodc_pkg::QUO_W];
		back = by100_q ? lodc_pkg::DATE_W'(quo_q) * DIV_SMALL_C
			: lodc_pkg::DATE_W'(quo_q) * DIV_BIG_C;
		rem_x = num_q - back;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= req.start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			by100_q <= req.by_100;
		end
		if (busy_q) begin
			quo_q <= quo_nx;
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem = rem_x[lodc_pkg::REM_W-1:0];

endmodule

// ===== rtl/loan_overdue_day_count.sv =====
// Top level of the loan overdue day counter: sequencer, day accumulator, output register.
`timescale 1ns / 1ps

// Takes a borrow date and a return date (decimal YYYYMMDD) and an allowance in days, and
// returns the days elapsed under Gregorian rules plus an overdue flag. One item at a time:
// the dates are split by a shared constant divider (reciprocal multiply, used for both
// dates and for the century split of the borrow year), then a set-up step starts the
// count, a year step goes year by year from the borrow year to the return year,
// and a last step loads the output register. The result appears as in_stall drops, so an
// item holds the block, and no new item is taken, until its result is loaded.
// in_stall is high while an item is in work; while a held result still sits in the output
// register the next result waits in the last step with in_stall high. A same-year return
// in an earlier month or a return in an earlier year gives 0, and an earlier day in the
// same month a negative count. Years are clamped to FIRST_YEAR..LAST_YEAR, months to 1..12.
module loan_overdue_day_count #(
	parameter int FIRST_YEAR = lodc_pkg::FIRST_YEAR_DEF,
	parameter int LAST_YEAR = lodc_pkg::LAST_YEAR_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [lodc_pkg::DATE_W-1:0]           borrow_date,
	input  logic [lodc_pkg::DATE_W-1:0]           return_date,
	input  logic [lodc_pkg::ALLOW_W-1:0]          allowed_days,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [lodc_pkg::ELAPSED_W-1:0] elapsed_days,
	output logic                                  overdue
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_D1Y = 4'd1;
	localparam logic [3:0] ST_D1M = 4'd2;
	localparam logic [3:0] ST_D2Y = 4'd3;
	localparam logic [3:0] ST_D2M = 4'd4;
	localparam logic [3:0] ST_Y1C = 4'd5;
	localparam logic [3:0] ST_INIT = 4'd6;
	localparam logic [3:0] ST_YEAR = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;

	localparam int ACC_W = lodc_pkg::ACC_W;
	localparam int YEAR_W = lodc_pkg::YEAR_W;
	localparam logic [YEAR_W-1:0] Y_FIRST = YEAR_W'(FIRST_YEAR);
	localparam logic [YEAR_W-1:0] Y_LAST = YEAR_W'(LAST_YEAR);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(lodc_pkg::ELAPSED_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(lodc_pkg::ELAPSED_MIN);
	localparam logic signed [ACC_W-1:0] YEAR_DAYS = ACC_W'(lodc_pkg::DAYS_YEAR);
	localparam logic [lodc_pkg::CENT_W-1:0] LAST_IN_CENT = lodc_pkg::CENT_W'(99);

	logic [3:0]                           state_q;
	logic [lodc_pkg::DATE_W-1:0]          ret_q;
	logic [lodc_pkg::ALLOW_W-1:0]         allow_q;
	logic [YEAR_W-1:0]                    y1_q;
	logic [YEAR_W-1:0]                    y2_q;
	logic [YEAR_W-1:0]                    yc_q;
	logic [lodc_pkg::MONTH_W-1:0]         m1_q;
	logic [lodc_pkg::MONTH_W-1:0]         m2_q;
	logic [lodc_pkg::DAY_W-1:0]           d1_q;
	logic [lodc_pkg::DAY_W-1:0]           d2_q;
	logic [lodc_pkg::CENT_W-1:0]          c_q;
	logic [lodc_pkg::DAY_W-1:0]           r_q;
	logic signed [ACC_W-1:0]              acc_q;
	logic                                 out_valid_q;
	logic signed [lodc_pkg::ELAPSED_W-1:0] elapsed_q;
	logic                                 overdue_q;

	lodc_pkg::div_req_t                   div_req;
	logic [lodc_pkg::DATE_W-1:0]          div_num;
	logic                                 div_done;
	logic [lodc_pkg::QUO_W-1:0]           div_quo;
	logic [lodc_pkg::REM_W-1:0]           div_rem;

	logic [YEAR_W-1:0]                    year_cl;
	logic [lodc_pkg::MONTH_W-1:0]         month_cl;
	logic                                 leap1;
	logic [lodc_pkg::DAY_W-1:0]           r_nx;
	logic [lodc_pkg::CENT_W-1:0]          c_nx;
	logic [YEAR_W-1:0]                    yc_nx;
	logic                                 leap_nx;
	logic signed [ACC_W-1:0]              db1_x;
	logic signed [ACC_W-1:0]              db2_x;
	logic signed [ACC_W-1:0]              dbn_x;
	logic signed [ACC_W-1:0]              d1_x;
	logic signed [ACC_W-1:0]              d2_x;
	logic signed [ACC_W-1:0]              allow_x;
	logic signed [ACC_W-1:0]              acc_same;
	logic signed [ACC_W-1:0]              acc_later;
	logic                                 out_free;

	lodc_cdiv u_cdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		year_cl = YEAR_W'(div_quo);
		if (year_cl < Y_FIRST) begin
			year_cl = Y_FIRST;
		end else if (year_cl > Y_LAST) begin
			year_cl = Y_LAST;
		end
		if (div_quo == '0) begin
			month_cl = lodc_pkg::MONTH_W'(1);
		end else if (div_quo > lodc_pkg::QUO_W'(lodc_pkg::MONTHS)) begin
			month_cl = lodc_pkg::MONTH_W'(lodc_pkg::MONTHS);
		end else begin
			month_cl = div_quo[lodc_pkg::MONTH_W-1:0];
		end
	end

	always_comb begin
		div_req = '0;
		div_num = '0;
		case (state_q)
			ST_IDLE: begin
				div_req.start = in_valid;
				div_num = borrow_date;
			end
			ST_D1Y: begin
				div_req.start = div_done;
				div_req.by_100 = 1'b1;
				div_num = lodc_pkg::DATE_W'(div_rem);
			end
			ST_D1M: begin
				div_req.start = div_done;
				div_num = ret_q;
			end
			ST_D2Y: begin
				div_req.start = div_done;
				div_req.by_100 = 1'b1;
				div_num = lodc_pkg::DATE_W'(div_rem);
			end
			ST_D2M: begin
				div_req.start = div_done;
				div_req.by_100 = 1'b1;
				div_num = lodc_pkg::DATE_W'(y1_q);
			end
			default: begin
				div_req = '0;
				div_num = '0;
			end
		endcase
	end

	always_comb begin
		leap1 = lodc_pkg::leap_of(c_q, r_q);
		db1_x = ACC_W'(lodc_pkg::days_before(leap1, m1_q));
		db2_x = ACC_W'(lodc_pkg::days_before(leap1, m2_q));
		d1_x = ACC_W'(d1_q);
		d2_x = ACC_W'(d2_q);
		allow_x = ACC_W'(allow_q);
		acc_same = (m2_q < m1_q) ? '0 : db2_x - db1_x + d2_x - d1_x;
		acc_later = YEAR_DAYS + ACC_W'(leap1) - db1_x - d1_x;
		if (r_q == LAST_IN_CENT) begin
			r_nx = '0;
			c_nx = c_q + 1'b1;
		end else begin
			r_nx = r_q + 1'b1;
			c_nx = c_q;
		end
		yc_nx = yc_q + 1'b1;
		leap_nx = lodc_pkg::leap_of(c_nx, r_nx);
		dbn_x = ACC_W'(lodc_pkg::days_before(leap_nx, m2_q));
		out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_D1Y;
				ST_D1Y: if (div_done) state_q <= ST_D1M;
				ST_D1M: if (div_done) state_q <= ST_D2Y;
				ST_D2Y: if (div_done) state_q <= ST_D2M;
				ST_D2M: if (div_done) state_q <= ST_Y1C;
				ST_Y1C: if (div_done) state_q <= ST_INIT;
				ST_INIT: state_q <= (y2_q > y1_q) ? ST_YEAR : ST_FIN;
				ST_YEAR: if (yc_nx == y2_q) state_q <= ST_FIN;
				ST_FIN: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ret_q <= return_date;
					allow_q <= allowed_days;
				end
			end
			ST_D1Y: if (div_done) y1_q <= year_cl;
			ST_D1M: begin
				if (div_done) begin
					m1_q <= month_cl;
					d1_q <= div_rem[lodc_pkg::DAY_W-1:0];
				end
			end
			ST_D2Y: if (div_done) y2_q <= year_cl;
			ST_D2M: begin
				if (div_done) begin
					m2_q <= month_cl;
					d2_q <= div_rem[lodc_pkg::DAY_W-1:0];
				end
			end
			ST_Y1C: begin
				if (div_done) begin
					c_q <= div_quo[lodc_pkg::CENT_W-1:0];
					r_q <= div_rem[lodc_pkg::DAY_W-1:0];
					yc_q <= y1_q;
				end
			end
			ST_INIT: begin
				if (y2_q == y1_q) begin
					acc_q <= acc_same;
				end else if (y2_q > y1_q) begin
					acc_q <= acc_later;
				end else begin
					acc_q <= '0;
				end
			end
			ST_YEAR: begin
				c_q <= c_nx;
				r_q <= r_nx;
				yc_q <= yc_nx;
				if (yc_nx == y2_q) begin
					acc_q <= acc_q + dbn_x + d2_x;
				end else begin
					acc_q <= acc_q + YEAR_DAYS + ACC_W'(leap_nx);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					if (acc_q > SAT_HI) begin
						elapsed_q <= SAT_HI[lodc_pkg::ELAPSED_W-1:0];
					end else if (acc_q < SAT_LO) begin
						elapsed_q <= SAT_LO[lodc_pkg::ELAPSED_W-1:0];
					end else begin
						elapsed_q <= acc_q[lodc_pkg::ELAPSED_W-1:0];
					end
					overdue_q <= (acc_q > allow_x);
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign elapsed_days = elapsed_q;
	assign overdue = overdue_q;

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input transfer did not start work");

	a_div_done_in_split: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_D1Y || state_q == ST_D1M || state_q == ST_D2Y ||
			state_q == ST_D2M || state_q == ST_Y1C))
		else $error("divider finished outside a split step");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_FIN)
		else $error("result shown without finishing an item");

	a_year_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (yc_q < y2_q))
		else $error("year loop ran past the return year");
`endif

endmodule

// ===== tb/sv/tb_loan_overdue_day_count.sv =====
// Testbench for loan_overdue_day_count: directed table, random dates, results checked against the table or a predictor.
`timescale 1ns / 1ps

module tb_loan_overdue_day_count;

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int HOLD_OFF_AFTER = 150;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;
	localparam int FIRST_YEAR = lodc_pkg::FIRST_YEAR_DEF;
	localparam int LAST_YEAR = lodc_pkg::LAST_YEAR_DEF;
	localparam int TOP_YEAR = 3354;
	localparam int NUM_CASES = 24;

	typedef logic [lodc_pkg::DATE_W-1:0] date_t;
	typedef logic [lodc_pkg::ALLOW_W-1:0] allow_t;
	typedef logic signed [lodc_pkg::ELAPSED_W-1:0] elapsed_t;

	typedef struct packed {
		elapsed_t elapsed;
		logic late;
	} loan_verdict_t;

	typedef struct packed {
		date_t borrow;
		date_t ret;
		allow_t allow;
		logic known;
		elapsed_t elapsed;
		logic late;
	} loan_case_t;

	localparam date_t DATE_ONES = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	date_t borrow_date;
	date_t return_date;
	allow_t allowed_days;
	logic out_valid;
	logic out_stall;
	elapsed_t elapsed_days;
	logic overdue;

	loan_verdict_t due_q[$];
	loan_verdict_t pend_verdict;
	int mismatches = 0;
	int items_in = 0;
	int idle_cycles = 0;

	loan_case_t loan_cases [0:NUM_CASES-1] = '{
		'{25'd20190101, 25'd20190101, 16'd0, 1'b1, 0, 1'b0},
		'{25'd20190101, 25'd20190102, 16'd0, 1'b1, 1, 1'b1},
		'{25'd20190501, 25'd20190301, 16'd0, 1'b1, 0, 1'b0},
		'{25'd20190315, 25'd20190310, 16'd0, 1'b1, -5, 1'b0},
		'{25'd20200101, 25'd20190101, 16'd0, 1'b1, 0, 1'b0},
		'{25'd20190101, 25'd20501231, 16'hFFFF, 1'b0, 0, 1'b0},
		'{25'd20190101, 25'd20501231, 16'd0, 1'b0, 0, 1'b0},
		'{25'd0, 25'd0, 16'd0, 1'b1, 0, 1'b0},
		'{DATE_ONES, DATE_ONES, 16'hFFFF, 1'b1, 0, 1'b0},
		'{25'd0, DATE_ONES, 16'd0, 1'b0, 0, 1'b0},
		'{25'd20190001, 25'd20190015, 16'd0, 1'b1, 14, 1'b1},
		'{25'd20191310, 25'd20199920, 16'd9, 1'b1, 10, 1'b1},
		'{25'd20190100, 25'd20190199, 16'd98, 1'b1, 99, 1'b1},
		'{25'd20190199, 25'd20190100, 16'd0, 1'b1, -99, 1'b0},
		'{25'd20181231, 25'd20190101, 16'd0, 1'b1, 0, 1'b0},
		'{25'd20510101, 25'd20600101, 16'd0, 1'b1, 0, 1'b0},
		'{25'd20191231, 25'd20200101, 16'd1, 1'b0, 0, 1'b0},
		'{25'd20200228, 25'd20200301, 16'd1, 1'b0, 0, 1'b0},
		'{25'd20190228, 25'd20190301, 16'd1, 1'b0, 0, 1'b0},
		'{25'd20231231, 25'd20240101, 16'd0, 1'b0, 0, 1'b0},
		'{25'd20190615, 25'd20190615, 16'hFFFF, 1'b1, 0, 1'b0},
		'{25'd20191299, 25'd20200100, 16'd0, 1'b0, 0, 1'b0},
		'{25'd20200101, 25'd20210101, 16'd365, 1'b0, 0, 1'b0},
		'{25'd20190101, 25'd20230101, 16'd1461, 1'b0, 0, 1'b0}
	};

	loan_overdue_day_count u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.borrow_date(borrow_date),
		.return_date(return_date),
		.allowed_days(allowed_days),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.elapsed_days(elapsed_days),
		.overdue(overdue)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int is_leap(input int y);
		return ((y % 100 != 0 && y % 4 == 0) || y % 400 == 0) ? 1 : 0;
	endfunction

	function automatic int leaps_through(input int y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic int month_len(input int y, input int m);
		case (m)
			2: return 28 + is_leap(y);
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic int day_of_year(input int y, input int m, input int d);
		int total;
		int i;
		total = d;
		for (i = 1; i < m; i++) begin
			total += month_len(y, i);
		end
		return total;
	endfunction

	function automatic void split_date(input date_t raw, output int y, output int m,
			output int d);
		int v;
		v = int'(raw);
		y = v / lodc_pkg::DIV_BIG;
		m = (v % lodc_pkg::DIV_BIG) / lodc_pkg::DIV_SMALL;
		d = v % lodc_pkg::DIV_SMALL;
		if (y < FIRST_YEAR) y = FIRST_YEAR;
		if (y > LAST_YEAR) y = LAST_YEAR;
		if (m < 1) m = 1;
		if (m > lodc_pkg::MONTHS) m = lodc_pkg::MONTHS;
	endfunction

	function automatic int count_loan_days(input date_t borrow, input date_t ret);
		int y1, m1, d1, y2, m2, d2;
		int sum;
		int i;
		split_date(borrow, y1, m1, d1);
		split_date(ret, y2, m2, d2);
		sum = 0;
		if (y2 == y1) begin
			if (m1 == m2) begin
				sum = d2 - d1;
			end else if (m2 > m1) begin
				sum = month_len(y1, m1) - d1 + d2;
				for (i = m1 + 1; i < m2; i++) begin
					sum += month_len(y1, i);
				end
			end
		end else if (y2 > y1) begin
			sum = lodc_pkg::DAYS_YEAR + is_leap(y1) - day_of_year(y1, m1, d1)
				+ day_of_year(y2, m2, d2);
			if (y2 - y1 > 1) begin
				sum += lodc_pkg::DAYS_YEAR * (y2 - y1 - 1)
					+ leaps_through(y2 - 1) - leaps_through(y1);
			end
		end
		return sum;
	endfunction

	function automatic loan_verdict_t predict_verdict(input date_t borrow, input date_t ret,
			input allow_t allow);
		loan_verdict_t v;
		int sum;
		int shown;
		sum = count_loan_days(borrow, ret);
		shown = sum;
		if (shown > lodc_pkg::ELAPSED_MAX) shown = lodc_pkg::ELAPSED_MAX;
		if (shown < lodc_pkg::ELAPSED_MIN) shown = lodc_pkg::ELAPSED_MIN;
		v.elapsed = elapsed_t'(shown);
		v.late = (sum > int'(allow));
		return v;
	endfunction

	function automatic date_t pack_date(input int y, input int m, input int d);
		return date_t'(y * lodc_pkg::DIV_BIG + m * lodc_pkg::DIV_SMALL + d);
	endfunction

	function automatic date_t any_day_in(input int y);
		int m;
		m = $urandom_range(1, lodc_pkg::MONTHS);
		return pack_date(y, m, $urandom_range(1, month_len(y, m)));
	endfunction

	function automatic date_t odd_date();
		int y;
		int sel;
		sel = $urandom_range(0, 2);
		if (sel == 0) begin
			y = $urandom_range(0, FIRST_YEAR - 1);
		end else if (sel == 1) begin
			y = $urandom_range(LAST_YEAR + 1, TOP_YEAR);
		end else begin
			y = $urandom_range(FIRST_YEAR, LAST_YEAR);
		end
		return pack_date(y, $urandom_range(0, 99), $urandom_range(0, 99));
	endfunction

	task automatic drive_loan(input date_t borrow, input date_t ret, input allow_t allow,
			input logic known, input elapsed_t elapsed, input logic late);
		if (known) begin
			pend_verdict = '{elapsed, late};
		end else begin
			pend_verdict = predict_verdict(borrow, ret, allow);
		end
		in_valid <= 1'b1;
		borrow_date <= borrow;
		return_date <= ret;
		allowed_days <= allow;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		loan_verdict_t want;
		if (arst_n && in_valid && !in_stall) begin
			due_q.push_back(pend_verdict);
			items_in++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (due_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer: elapsed_days %0d overdue %0b",
					$time, elapsed_days, overdue);
			end else begin
				want = due_q.pop_front();
				if (elapsed_days !== want.elapsed) begin
					mismatches++;
					$display("%0t: elapsed_days expected %0d actual %0d",
						$time, want.elapsed, elapsed_days);
				end
				if (overdue !== want.late) begin
					mismatches++;
					$display("%0t: overdue expected %0b actual %0b",
						$time, want.late, overdue);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int mode;
		int left;
		int i;
		logic held_off;
		mode = 0;
		left = 0;
		held_off = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && items_in >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				for (i = 0; i < HOLD_OFF_CYCLES; i++) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	initial begin
		int n;
		int kind;
		int burst_left;
		int y1;
		int m;
		int near;
		date_t borrow;
		date_t ret;
		allow_t allow;
		arst_n = 1'b0;
		in_valid = 1'b0;
		borrow_date = '0;
		return_date = '0;
		allowed_days = '0;
		burst_left = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (n = 0; n < NUM_CASES; n++) begin
			drive_loan(loan_cases[n].borrow, loan_cases[n].ret, loan_cases[n].allow,
				loan_cases[n].known, loan_cases[n].elapsed, loan_cases[n].late);
		end
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
			end
			burst_left--;
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				y1 = $urandom_range(FIRST_YEAR, LAST_YEAR);
				borrow = any_day_in(y1);
				ret = any_day_in($urandom_range(y1, LAST_YEAR));
			end else if (kind < 68) begin
				borrow = any_day_in($urandom_range(FIRST_YEAR, LAST_YEAR));
				ret = any_day_in($urandom_range(FIRST_YEAR, LAST_YEAR));
			end else if (kind < 78) begin
				y1 = $urandom_range(FIRST_YEAR, LAST_YEAR);
				borrow = any_day_in(y1);
				ret = any_day_in(y1);
			end else if (kind < 84) begin
				y1 = $urandom_range(FIRST_YEAR, LAST_YEAR);
				m = $urandom_range(1, lodc_pkg::MONTHS);
				borrow = pack_date(y1, m, $urandom_range(1, month_len(y1, m)));
				ret = pack_date(y1, m, $urandom_range(1, month_len(y1, m)));
			end else if (kind < 92) begin
				borrow = odd_date();
				ret = odd_date();
			end else begin
				borrow = date_t'($urandom());
				ret = date_t'($urandom());
			end
			if ($urandom_range(0, 1) == 0) begin
				allow = allow_t'($urandom());
			end else begin
				near = count_loan_days(borrow, ret) + $urandom_range(0, 4) - 2;
				allow = (near < 0) ? '0 : allow_t'(near);
			end
			drive_loan(borrow, ret, allow, 1'b0, '0, 1'b0);
		end
		in_valid <= 1'b0;
		while (due_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lodc_pkg.sv
rtl/lodc_cdiv.sv
rtl/loan_overdue_day_count.sv
tb/sv/tb_loan_overdue_day_count.sv
